### sv/kmpc_pkg.sv
// ----------------------------------------------------------------------------
// kmpc_pkg
// shared types and codes for the kmp pattern match counter
// ----------------------------------------------------------------------------
package kmpc_pkg;

    localparam int KMPC_MAX_PATTERN = 128;
    localparam int COUNT_W          = 32;

    localparam logic       OP_PATTERN = 1'b0;
    localparam logic       OP_TEXT    = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NO_PATTERN = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_HIT,
        S_HIT_WAIT,
        S_DONE
    } t_state;

endpackage

### sv/kmp_pattern_match_counter_core.sv
// ----------------------------------------------------------------------------
// kmp_pattern_match_counter_core
// knuth-morris-pratt search: builds the failure table as pattern bytes arrive
// and counts (overlapping, saturating) occurrences over text bytes
// ----------------------------------------------------------------------------
// sequence: idle, then read and compare once per failure-link compare, then
//   hit and hit-wait when a match completes, then done; the first pattern
//   byte, a rejected pattern byte or text without pattern go from idle to done
// throughput: one request at a time, the walk shares one registered read port
//   per store, so each compare step passes a read and a compare state; a
//   stalled result holds off the next request
// reset: synchronous active low, clears length, positions and count; the
//   stores are not cleared and only written entries are ever read
// ----------------------------------------------------------------------------
module kmp_pattern_match_counter_core #(
    parameter int MAX_PATTERN = kmpc_pkg::KMPC_MAX_PATTERN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_match_end,
    output logic [31:0] o_occurrence_count,
    output logic [1:0]  o_status
);
    import kmpc_pkg::*;

    localparam int AW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);

    t_state             r_state, n_state;
    logic [LW-1:0]      r_len, n_len;
    logic [AW-1:0]      r_bpl, n_bpl;
    logic [AW-1:0]      r_pos, n_pos;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [LW-1:0]      r_k, n_k;
    logic               r_op, n_op;
    logic [7:0]         r_c, n_c;
    logic               r_hit, n_hit;
    logic [1:0]         r_status, n_status;
    logic               r_out_valid, n_out_valid;
    logic               r_out_match, n_out_match;
    logic [COUNT_W-1:0] r_out_count, n_out_count;
    logic [1:0]         r_out_status, n_out_status;

    logic               pat_we, pre_we;
    logic [AW-1:0]      pat_waddr, pre_waddr, pre_wdata;
    logic [7:0]         pat_wdata, pat_rdata;
    logic [AW-1:0]      pat_raddr, pre_raddr, pre_rdata;

    logic [LW-1:0]      len_m1, k_m1, eff_len, pos_eff, k_inc;
    logic               eq;

    kmpc_mem #(
        .MAX_PATTERN (MAX_PATTERN),
        .AW          (AW)
    ) u_mem (
        .i_clk       (i_clk),
        .i_pat_we    (pat_we),
        .i_pat_waddr (pat_waddr),
        .i_pat_wdata (pat_wdata),
        .i_pat_raddr (pat_raddr),
        .o_pat_rdata (pat_rdata),
        .i_pre_we    (pre_we),
        .i_pre_waddr (pre_waddr),
        .i_pre_wdata (pre_wdata),
        .i_pre_raddr (pre_raddr),
        .o_pre_rdata (pre_rdata)
    );

    assign len_m1    = r_len - LW'(1);
    assign k_m1      = r_k - LW'(1);
    assign pat_raddr = r_k[AW-1:0];
    assign pre_raddr = (r_state == S_HIT) ? len_m1[AW-1:0] : k_m1[AW-1:0];
    assign eq        = (pat_rdata == r_c);
    assign k_inc     = r_k + (eq ? LW'(1) : LW'(0));
    assign eff_len   = i_first ? '0 : r_len;
    assign pos_eff   = i_first ? '0 : LW'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_bpl       <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_bpl       <= n_bpl;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_op         <= n_op;
        r_c          <= n_c;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_out_match  <= n_out_match;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_bpl        = r_bpl;
        n_pos        = r_pos;
        n_count      = r_count;
        n_k          = r_k;
        n_op         = r_op;
        n_c          = r_c;
        n_hit        = r_hit;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_match  = r_out_match;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        pat_we       = 1'b0;
        pat_waddr    = eff_len[AW-1:0];
        pat_wdata    = i_byte_value;
        pre_we       = 1'b0;
        pre_waddr    = r_len[AW-1:0];
        pre_wdata    = k_inc[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_opcode;
                    n_c      = i_byte_value;
                    n_hit    = 1'b0;
                    n_status = STATUS_OK;
                    n_state  = S_DONE;
                    if (i_opcode == OP_PATTERN) begin
                        if (i_first) begin
                            n_len   = '0;
                            n_bpl   = '0;
                            n_pos   = '0;
                            n_count = '0;
                        end
                        if (eff_len >= LW'(MAX_PATTERN)) begin
                            n_status = STATUS_TOO_LONG;
                        end else begin
                            pat_we = 1'b1;
                            if (eff_len == '0) begin
                                pre_we    = 1'b1;
                                pre_waddr = '0;
                                pre_wdata = '0;
                                n_bpl     = '0;
                                n_len     = LW'(1);
                            end else begin
                                n_k     = LW'(r_bpl);
                                n_state = S_READ;
                            end
                        end
                    end else begin
                        if (i_first) begin
                            n_pos   = '0;
                            n_count = '0;
                        end
                        if (r_len == '0) begin
                            n_status = STATUS_NO_PATTERN;
                        end else begin
                            n_k     = (pos_eff >= r_len) ? '0 : pos_eff;
                            n_state = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_k != '0 && !eq) begin
                    n_k     = LW'(pre_rdata);
                    n_state = S_READ;
                end else if (r_op == OP_PATTERN) begin
                    pre_we  = 1'b1;
                    n_bpl   = k_inc[AW-1:0];
                    n_len   = r_len + LW'(1);
                    n_state = S_DONE;
                end else if (k_inc == r_len) begin
                    n_hit = 1'b1;
                    if (r_count != '1) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    n_state = S_HIT;
                end else begin
                    n_pos   = k_inc[AW-1:0];
                    n_state = S_DONE;
                end
            end
            S_HIT: begin
                n_state = S_HIT_WAIT;
            end
            S_HIT_WAIT: begin
                n_pos   = pre_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_match  = r_hit;
                    n_out_count  = r_count;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_match_end        = r_out_match;
    assign o_occurrence_count = r_out_count;
    assign o_status           = r_out_status;

endmodule

### sv/kmpc_mem.sv
// ----------------------------------------------------------------------------
// kmpc_mem
// pattern byte store and failure table, one write and one registered read
// port each
// ----------------------------------------------------------------------------
module kmpc_mem #(
    parameter int MAX_PATTERN = kmpc_pkg::KMPC_MAX_PATTERN,
    parameter int AW          = $clog2(MAX_PATTERN)
) (
    input  logic          i_clk,
    input  logic          i_pat_we,
    input  logic [AW-1:0] i_pat_waddr,
    input  logic [7:0]    i_pat_wdata,
    input  logic [AW-1:0] i_pat_raddr,
    output logic [7:0]    o_pat_rdata,
    input  logic          i_pre_we,
    input  logic [AW-1:0] i_pre_waddr,
    input  logic [AW-1:0] i_pre_wdata,
    input  logic [AW-1:0] i_pre_raddr,
    output logic [AW-1:0] o_pre_rdata
);
    import kmpc_pkg::*;

    logic [7:0]    pat_mem [MAX_PATTERN];
    logic [AW-1:0] pre_mem [MAX_PATTERN];
    logic [7:0]    r_pat_rd;
    logic [AW-1:0] r_pre_rd;

    always_ff @(posedge i_clk) begin
        if (i_pat_we) begin
            pat_mem[i_pat_waddr] <= i_pat_wdata;
        end
        r_pat_rd <= pat_mem[i_pat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_pre_we) begin
            pre_mem[i_pre_waddr] <= i_pre_wdata;
        end
        r_pre_rd <= pre_mem[i_pre_raddr];
    end

    assign o_pat_rdata = r_pat_rd;
    assign o_pre_rdata = r_pre_rd;

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// kmp pattern match counter: directed checks of empty, overlapping, single
// byte, grown and full patterns, then random pattern/text sequences under
// random sender gaps and receiver stalls, all results checked in order
// against a cycle-free model of the search kept in the bench
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kmpc_pkg::*;

    typedef struct {
        logic        match_end;
        logic [31:0] count;
        logic [1:0]  status;
    } t_search_result;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_opcode     = OP_PATTERN;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_first      = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_match_end;
    logic [31:0] o_occurrence_count;
    logic [1:0]  o_status;

    t_search_result expected_results[$];
    int error_count = 0;
    int sent_count  = 0;
    int burst_left  = 0;

    // search state mirrored in the bench
    logic [7:0]  pat_bytes [KMPC_MAX_PATTERN];
    int unsigned fail_link [KMPC_MAX_PATTERN];
    int unsigned pat_len   = 0;
    int unsigned build_k   = 0;
    int unsigned match_pos = 0;
    logic [31:0] occ_count = '0;

    logic [7:0] alphabet [3];
    int         alphabet_size = 1;

    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;

    kmp_pattern_match_counter_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_byte_value       (i_byte_value),
        .i_first            (i_first),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_match_end        (o_match_end),
        .o_occurrence_count (o_occurrence_count),
        .o_status           (o_status)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_search_result search_step(input logic op, input logic [7:0] value,
                                                   input logic first);
        t_search_result r;
        int unsigned    k;
        int unsigned    j;
        r.match_end = 1'b0;
        r.status    = STATUS_OK;
        if (op == OP_PATTERN) begin
            if (first) begin
                pat_len   = 0;
                build_k   = 0;
                match_pos = 0;
                occ_count = '0;
            end
            if (pat_len >= KMPC_MAX_PATTERN) begin
                r.status = STATUS_TOO_LONG;
            end else begin
                pat_bytes[pat_len] = value;
                if (pat_len == 0) begin
                    fail_link[0] = 0;
                    build_k      = 0;
                end else begin
                    k = build_k;
                    while (k > 0 && pat_bytes[k] != value)
                        k = fail_link[k - 1];
                    if (pat_bytes[k] == value)
                        k++;
                    fail_link[pat_len] = k;
                    build_k            = k;
                end
                pat_len++;
            end
        end else begin
            if (first) begin
                match_pos = 0;
                occ_count = '0;
            end
            if (pat_len == 0) begin
                r.status = STATUS_NO_PATTERN;
            end else begin
                j = (match_pos >= pat_len) ? 0 : match_pos;
                while (j > 0 && pat_bytes[j] != value)
                    j = fail_link[j - 1];
                if (pat_bytes[j] == value)
                    j++;
                if (j == pat_len) begin
                    r.match_end = 1'b1;
                    if (occ_count != 32'hFFFF_FFFF)
                        occ_count++;
                    j = fail_link[pat_len - 1];
                end
                match_pos = j;
            end
        end
        r.count = occ_count;
        return r;
    endfunction

    function automatic void new_alphabet();
        alphabet_size = $urandom_range(1, 3);
        foreach (alphabet[i])
            alphabet[i] = 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_char();
        return alphabet[$urandom_range(0, alphabet_size - 1)];
    endfunction

    task automatic send_request(input logic op, input logic [7:0] value, input logic first);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 20);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_byte_value <= value;
        i_first      <= first;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(search_step(op, value, first));
        burst_left--;
        sent_count++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_no_pattern();
        send_request(OP_TEXT, 8'h00, 1'b0);
        send_request(OP_TEXT, 8'hFF, 1'b1);
        // pattern byte with nothing loaded starts a pattern even with first low
        send_request(OP_PATTERN, 8'h00, 1'b0);
    endtask

    task automatic test_overlapping_matches();
        send_request(OP_PATTERN, 8'hFF, 1'b0);
        send_request(OP_PATTERN, 8'h00, 1'b0);
        for (int i = 0; i < 7; i++)
            send_request(OP_TEXT, (i % 2) ? 8'hFF : 8'h00, i == 0);
        send_request(OP_TEXT, 8'hFF, 1'b1);
        send_request(OP_PATTERN, 8'hFF, 1'b1);
        repeat (3) send_request(OP_TEXT, 8'hFF, 1'b0);
        // grow the pattern while the text runs
        send_request(OP_PATTERN, 8'hFF, 1'b0);
        repeat (2) send_request(OP_TEXT, 8'hFF, 1'b0);
        wait_all_results();
    endtask

    task automatic test_full_pattern();
        for (int i = 0; i < KMPC_MAX_PATTERN; i++)
            send_request(OP_PATTERN, 8'h61, i == 0);
        send_request(OP_PATTERN, 8'h61, 1'b0);
        send_request(OP_PATTERN, 8'hFF, 1'b0);
        send_request(OP_PATTERN, 8'h00, 1'b0);
        for (int i = 0; i < 135; i++)
            send_request(OP_TEXT, 8'h61, i == 0);
        // mismatch at the end of a long run walks the whole failure chain
        send_request(OP_TEXT, 8'h62, 1'b0);
        for (int i = 0; i < 130; i++)
            send_request(OP_TEXT, 8'h61, 1'b0);
        wait_all_results();
    endtask

    task automatic test_random_search();
        int   plen;
        int   tlen;
        logic grow;
        while (sent_count < 1450) begin
            case ($urandom_range(0, 19))
                0: begin
                    repeat ($urandom_range(1, 10))
                        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                     $urandom_range(0, 3) == 0);
                end
                1: begin
                    wait_all_results();
                end
                default: begin
                    grow = ($urandom_range(0, 9) == 0);
                    if (!grow)
                        new_alphabet();
                    plen = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 132)
                                                        : $urandom_range(1, 8);
                    for (int i = 0; i < plen; i++)
                        send_request(OP_PATTERN, pick_char(), (i == 0) && !grow);
                    tlen = $urandom_range(1, 40);
                    for (int i = 0; i < tlen; i++)
                        send_request(OP_TEXT,
                                     ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                                 : pick_char(),
                                     ((i == 0) && ($urandom_range(0, 4) != 0))
                                         || ($urandom_range(0, 29) == 0));
                end
            endcase
        end
    endtask

    // receiver stall pattern, switching mode every so often
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 256);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin : check_results
        t_search_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: match_end %0b occurrence_count %0d status %0d",
                       o_match_end, o_occurrence_count, o_status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_match_end !== want.match_end) begin
                    $error("match_end: expected %0b, got %0b", want.match_end, o_match_end);
                    error_count++;
                end
                if (o_occurrence_count !== want.count) begin
                    $error("occurrence_count: expected %0d, got %0d",
                           want.count, o_occurrence_count);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_no_pattern();
        test_overlapping_matches();
        test_full_pattern();
        test_random_search();
        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
sv/kmpc_pkg.sv
sv/kmpc_mem.sv
sv/kmp_pattern_match_counter_core.sv
tb/testbench.sv
